@@ rtl/core/fwpct_pkg.sv @@
// ----------------------------------------------------------------------------
// fwpct_pkg
// Shared types, constants and replacement tables of the four-way tag store.
// ----------------------------------------------------------------------------
package fwpct_pkg;

    localparam int ADDR_W = 32;
    localparam int WAYS   = 4;
    localparam int WAY_W  = 2;
    localparam int TREE_W = 3;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef logic [WAY_W-1:0]  t_way;
    typedef logic [TREE_W-1:0] t_tree;

    // Victim way for each tree state
    localparam t_way VICTIM_OF [8] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
    };

    // Next tree state, indexed by {state, referenced way}
    localparam t_tree TREE_NEXT [32] = '{
        3'd6, 3'd4, 3'd1, 3'd0,
        3'd7, 3'd5, 3'd1, 3'd0,
        3'd6, 3'd4, 3'd3, 3'd2,
        3'd7, 3'd5, 3'd3, 3'd2,
        3'd6, 3'd4, 3'd1, 3'd0,
        3'd7, 3'd5, 3'd1, 3'd0,
        3'd6, 3'd4, 3'd3, 3'd2,
        3'd7, 3'd5, 3'd3, 3'd2
    };

    function automatic t_way victim_of(input t_tree tree);
        return VICTIM_OF[tree];
    endfunction

    function automatic t_tree tree_next(input t_tree tree, input t_way way);
        return TREE_NEXT[{tree, way}];
    endfunction

endpackage

@@ rtl/core/fwpct_ram.sv @@
// ----------------------------------------------------------------------------
// fwpct_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fwpct_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/fwpct_set_index.sv @@
// ----------------------------------------------------------------------------
// fwpct_set_index
// Set index of a line address: the line address modulo SETS. A power-of-two
// set count is a mask; any other count is reduced one hex digit per cycle.
// ----------------------------------------------------------------------------
module fwpct_set_index #(
    parameter int SETS = 32,
    parameter int BW   = 27,
    localparam int SW  = $clog2(SETS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [BW-1:0] i_block,
    output logic          o_done,
    output logic [SW-1:0] o_set
);

    generate
        if ((SETS & (SETS - 1)) == 0) begin : g_mask
            logic          r_done;
            logic [SW-1:0] r_set;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_set <= i_block[SW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_set  = r_set;
        end else begin : g_serial
            localparam int ND = (BW + 3) / 4;
            localparam int PW = ND * 4;
            localparam int CW = $clog2(ND + 1);
            localparam int RW = SW + 5;

            logic          r_busy;
            logic          r_done;
            logic [CW-1:0] r_cnt;
            logic [PW-1:0] r_sh;
            logic [SW-1:0] r_rem;
            logic [RW-1:0] v;
            logic [RW-1:0] lim;

            // Fold in the next digit, then bring the partial remainder back
            // below SETS with four compare-subtract steps.
            always_comb begin
                v = {1'b0, r_rem, r_sh[PW-1 -: 4]};
                for (int k = 3; k >= 0; k--) begin
                    lim = RW'(SETS) << k;
                    if (v >= lim) begin
                        v = v - lim;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= CW'(ND);
                    end else if (r_busy) begin
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == CW'(1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
                if (i_start) begin
                    r_sh  <= PW'(i_block);
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_sh  <= r_sh << 4;
                    r_rem <= v[SW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_set  = r_rem;
        end
    endgenerate

endmodule

@@ rtl/core/four_way_plru_cache_tags.sv @@
// ----------------------------------------------------------------------------
// four_way_plru_cache_tags
// Tag store of a four-way set-associative write-back cache with a 3-bit
// tree pseudo-LRU per set. Reports hit, way and writeback for each access.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  access  | in        | i_in_valid / o_in_ready   | i_cmd, i_address
//  result  | out       | o_out_valid / i_out_ready | o_hit, o_way, o_writeback
//
//  One access is in flight at a time. With a power-of-two SETS an access
//  passes through set index, then memory read, and the next beat is taken
//  in the cycle its predecessor writes back. Other set counts compute the
//  set index in the serial modulo unit instead.
//  After reset a clearing pass over every set zeroes valid and tree state;
//  no beat is taken during it. A full result register holds the access in
//  lookup, which stalls both its write-back and the next beat.
//
module four_way_plru_cache_tags #(
    parameter int SETS        = 32,
    parameter int OFFSET_BITS = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [fwpct_pkg::ADDR_W-1:0] i_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_hit,
    output logic [fwpct_pkg::WAY_W-1:0] o_way,
    output logic                        o_writeback
);

    localparam int WAYS   = fwpct_pkg::WAYS;
    localparam int TREE_W = fwpct_pkg::TREE_W;
    localparam int WAY_W  = fwpct_pkg::WAY_W;
    // The stored tag is the whole line address. Within one set that compares
    // exactly like the quotient by SETS, and no divider is needed.
    localparam int TW     = fwpct_pkg::ADDR_W - OFFSET_BITS;
    localparam int SW     = $clog2(SETS);
    localparam int LINE_W = WAYS * (TW + 1);
    localparam int META_W = TREE_W + WAYS;

    // Sequencer states
    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_INDEX  = 2'd2;
    localparam logic [1:0] S_LOOKUP = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [SW-1:0]     r_clr_cnt;
    logic              r_cmd;
    logic [TW-1:0]     r_block;

    logic              r_out_valid;
    logic              r_hit;
    fwpct_pkg::t_way   r_way;
    logic              r_wb;

    logic              accept;
    logic              complete;
    logic              idx_done;
    logic [SW-1:0]     idx_set;

    logic [LINE_W-1:0] line_q;
    logic [META_W-1:0] meta_q;
    logic [LINE_W-1:0] n_line;
    logic [META_W-1:0] n_meta;
    logic              meta_we;
    logic [SW-1:0]     meta_waddr;
    logic [META_W-1:0] meta_wdata;

    logic [TW-1:0]     way_tag [WAYS];
    logic [WAYS-1:0]   way_valid;
    logic [WAYS-1:0]   way_dirty;
    logic [WAYS-1:0]   match;
    fwpct_pkg::t_tree  tree;
    logic              lk_hit;
    logic              lk_free;
    fwpct_pkg::t_way   hit_way;
    fwpct_pkg::t_way   free_way;
    fwpct_pkg::t_way   lk_way;
    logic              lk_wb;

    // ---------------------------------------------------------------------
    // Handshakes: take a beat when idle, or in the cycle the current access
    // retires into the result register.
    // ---------------------------------------------------------------------
    assign complete   = (r_state == S_LOOKUP) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || complete;
    assign accept     = i_in_valid && o_in_ready;

    fwpct_set_index #(
        .SETS (SETS),
        .BW   (TW)
    ) u_set_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_block (i_address[fwpct_pkg::ADDR_W-1:OFFSET_BITS]),
        .o_done  (idx_done),
        .o_set   (idx_set)
    );

    // Tags and dirty bits: never cleared, only read for valid ways.
    fwpct_ram #(
        .DEPTH (SETS),
        .WIDTH (LINE_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (complete),
        .i_waddr (idx_set),
        .i_wdata (n_line),
        .i_raddr (idx_set),
        .o_rdata (line_q)
    );

    // Valid bits and tree state: zeroed by the clearing pass.
    fwpct_ram #(
        .DEPTH (SETS),
        .WIDTH (META_W)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (idx_set),
        .o_rdata (meta_q)
    );

    assign meta_we    = (r_state == S_CLEAR) || complete;
    assign meta_waddr = (r_state == S_CLEAR) ? r_clr_cnt : idx_set;
    assign meta_wdata = (r_state == S_CLEAR) ? '0 : n_meta;

    // ---------------------------------------------------------------------
    // Lookup on the set read out of memory: compare all four ways at once,
    // pick hit way, else first free way, else the pLRU victim.
    // ---------------------------------------------------------------------
    always_comb begin
        tree      = meta_q[META_W-1 -: TREE_W];
        way_valid = meta_q[WAYS-1:0];
        way_dirty = line_q[WAYS*TW +: WAYS];
        for (int w = 0; w < WAYS; w++) begin
            way_tag[w] = line_q[w*TW +: TW];
            match[w]   = way_valid[w] && (way_tag[w] == r_block);
        end

        lk_hit   = |match;
        lk_free  = ~&way_valid;
        hit_way  = '0;
        free_way = '0;
        // Walk down so the lowest-numbered way wins.
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!way_valid[w]) begin
                free_way = WAY_W'(w);
            end
        end

        if (lk_hit) begin
            lk_way = hit_way;
        end else if (lk_free) begin
            lk_way = free_way;
        end else begin
            lk_way = fwpct_pkg::victim_of(tree);
        end
        lk_wb = !lk_hit && !lk_free && way_dirty[lk_way];

        // Modify the row: fill on a miss, then mark dirty on a write.
        n_line = line_q;
        if (!lk_hit) begin
            n_line[lk_way*TW +: TW]        = r_block;
            n_line[WAYS*TW + 32'(lk_way)]  = (r_cmd == fwpct_pkg::CMD_WRITE);
        end else if (r_cmd == fwpct_pkg::CMD_WRITE) begin
            n_line[WAYS*TW + 32'(lk_way)]  = 1'b1;
        end
        n_meta = {fwpct_pkg::tree_next(tree, lk_way),
                  way_valid | (WAYS'(1) << lk_way)};
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == SW'(SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_INDEX;
                end
            end
            S_INDEX: begin
                if (idx_done) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (complete) begin
                    n_state = accept ? S_INDEX : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (complete) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        // Hold the access fields until it retires.
        if (accept) begin
            r_cmd   <= i_cmd;
            r_block <= i_address[fwpct_pkg::ADDR_W-1:OFFSET_BITS];
        end
        if (complete) begin
            r_hit <= lk_hit;
            r_way <= lk_way;
            r_wb  <= lk_wb;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_way       = r_way;
    assign o_writeback = r_wb;

`ifndef SYNTHESIS
    // A set never holds the same line in two ways.
    a_no_dup_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP) |-> $onehot0(match))
        else $error("duplicate tag in one set");

    // No beat is taken during the clearing pass.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("beat accepted during clear");

    // An accepted beat starts the index computation.
    a_accept_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_INDEX))
        else $error("accepted beat did not enter index state");

    // A retiring access always lands in the result register.
    a_complete_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        complete |=> r_out_valid)
        else $error("retired access lost");

    // A hit never reports a writeback.
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_wb))
        else $error("writeback reported on a hit");
`endif

endmodule

@@ tb/four_way_plru_cache_tags_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_way_plru_cache_tags_tb
// Self-checking bench for the four-way pLRU cache tag store. A table of
// directed accesses is followed by random traffic aimed at a few hot sets.
// A shadow copy of tags, valid, dirty and tree state predicts every result.
// ----------------------------------------------------------------------------
module four_way_plru_cache_tags_tb;

    // Geometry at the default parameters: index is address 9:5, tag is 31:10
    localparam int SETS     = 32;
    localparam int TAG_W    = 22;
    localparam int TAG_POOL = 6;
    localparam int N_DIR    = 20;

    // Result of one access as the block reports it
    typedef struct packed {
        logic            hit;
        fwpct_pkg::t_way way;
        logic            writeback;
    } t_lookup;

    // One row of the directed table; res is only used where known is set
    typedef struct packed {
        logic        cmd;
        logic [31:0] addr;
        logic        known;
        t_lookup     res;
    } t_access_row;

    // Tree pLRU: victim way per state, and next state indexed by {state, way}
    localparam fwpct_pkg::t_way PLRU_VICTIM [8] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
    };
    localparam logic [2:0] PLRU_STEP [32] = '{
        3'd6, 3'd4, 3'd1, 3'd0,  3'd7, 3'd5, 3'd1, 3'd0,
        3'd6, 3'd4, 3'd3, 3'd2,  3'd7, 3'd5, 3'd3, 3'd2,
        3'd6, 3'd4, 3'd1, 3'd0,  3'd7, 3'd5, 3'd1, 3'd0,
        3'd6, 3'd4, 3'd3, 3'd2,  3'd7, 3'd5, 3'd3, 3'd2
    };

    // Directed accesses. Set 0 is filled way by way, then driven into
    // evictions of clean and dirty lines; set 31 and the alternating-bit
    // addresses cover the address extremes. First fills and plain hits carry
    // a typed result, the eviction rows rely on the shadow model.
    localparam t_access_row DIRECTED [N_DIR] = '{
        '{fwpct_pkg::CMD_READ,  32'h0000_0000, 1'b1, '{1'b0, 2'd0, 1'b0}},
        '{fwpct_pkg::CMD_WRITE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 1'b0}},
        '{fwpct_pkg::CMD_READ,  32'hFFFF_FFE0, 1'b1, '{1'b1, 2'd0, 1'b0}},
        '{fwpct_pkg::CMD_WRITE, 32'h0000_001F, 1'b1, '{1'b1, 2'd0, 1'b0}},
        '{fwpct_pkg::CMD_READ,  32'h0000_0400, 1'b1, '{1'b0, 2'd1, 1'b0}},
        '{fwpct_pkg::CMD_WRITE, 32'h0000_0800, 1'b1, '{1'b0, 2'd2, 1'b0}},
        '{fwpct_pkg::CMD_READ,  32'hFFFF_FC00, 1'b1, '{1'b0, 2'd3, 1'b0}},
        '{fwpct_pkg::CMD_READ,  32'h0000_0C00, 1'b0, '0},
        '{fwpct_pkg::CMD_WRITE, 32'h0000_1000, 1'b0, '0},
        '{fwpct_pkg::CMD_READ,  32'h0000_0800, 1'b0, '0},
        '{fwpct_pkg::CMD_WRITE, 32'h0000_1400, 1'b0, '0},
        '{fwpct_pkg::CMD_READ,  32'h0000_0400, 1'b0, '0},
        '{fwpct_pkg::CMD_READ,  32'hFFFF_FC1F, 1'b0, '0},
        '{fwpct_pkg::CMD_WRITE, 32'h0000_1800, 1'b0, '0},
        '{fwpct_pkg::CMD_READ,  32'h0000_1C00, 1'b0, '0},
        '{fwpct_pkg::CMD_WRITE, 32'hAAAA_AAAA, 1'b1, '{1'b0, 2'd0, 1'b0}},
        '{fwpct_pkg::CMD_READ,  32'h5555_5555, 1'b1, '{1'b0, 2'd0, 1'b0}},
        '{fwpct_pkg::CMD_READ,  32'hAAAA_AAA0, 1'b1, '{1'b1, 2'd0, 1'b0}},
        '{fwpct_pkg::CMD_WRITE, 32'h5555_5540, 1'b1, '{1'b1, 2'd0, 1'b0}},
        '{fwpct_pkg::CMD_READ,  32'h0000_0000, 1'b0, '0}
    };

    // DUT ports; the inputs are all known from time zero
    logic            i_clk;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_ready;
    logic            i_cmd       = 1'b0;
    logic [31:0]     i_address   = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    logic            o_hit;
    fwpct_pkg::t_way o_way;
    logic            o_writeback;

    // Shadow tag store
    logic [TAG_W-1:0] tag_shadow   [SETS][4];
    logic             valid_shadow [SETS][4];
    logic             dirty_shadow [SETS][4];
    logic [2:0]       plru_shadow  [SETS];

    t_lookup          pending_results [$];
    logic [TAG_W-1:0] tag_pool [TAG_POOL];

    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    int  rx_hold      = 0;
    bit  offering     = 1'b0;
    int  mismatches   = 0;
    int  n_accesses   = 0;
    int  n_hits       = 0;
    int  n_writebacks = 0;
    int  n_results    = 0;

    four_way_plru_cache_tags i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_address   (i_address),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hit       (o_hit),
        .o_way       (o_way),
        .o_writeback (o_writeback)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit: far beyond the slowest legal run
    initial begin
        #1ms;
        $display("%0t: timeout, %0d results still outstanding", $time,
                 pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Look up one access in the shadow store, update it, return the result
    function automatic t_lookup predict_lookup(input logic cmd, input logic [31:0] addr);
        logic [4:0]       set_idx;
        logic [TAG_W-1:0] tag;
        t_lookup          res;
        bit               found;
        set_idx = addr[9:5];
        tag     = addr[31:10];
        res     = '0;
        found   = 1'b0;
        for (int w = 0; w < 4; w++) begin
            if (!res.hit && valid_shadow[set_idx][w] && tag_shadow[set_idx][w] == tag) begin
                res.hit = 1'b1;
                res.way = fwpct_pkg::t_way'(w);
            end
        end
        if (!res.hit) begin
            // Fill the lowest invalid way, else evict the tree's victim
            for (int w = 0; w < 4; w++) begin
                if (!found && !valid_shadow[set_idx][w]) begin
                    res.way = fwpct_pkg::t_way'(w);
                    found   = 1'b1;
                end
            end
            if (!found) begin
                res.way       = PLRU_VICTIM[plru_shadow[set_idx]];
                res.writeback = dirty_shadow[set_idx][res.way];
            end
            valid_shadow[set_idx][res.way] = 1'b1;
            tag_shadow[set_idx][res.way]   = tag;
            dirty_shadow[set_idx][res.way] = 1'b0;
        end
        plru_shadow[set_idx] = PLRU_STEP[{plru_shadow[set_idx], res.way}];
        if (cmd == fwpct_pkg::CMD_WRITE)
            dirty_shadow[set_idx][res.way] = 1'b1;
        return res;
    endfunction

    // Drop valid unless it is already low
    task automatic release_access_bus();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offer one access beat, wait for it to be taken, then log the expected result
    task automatic offer_access(input logic cmd, input logic [31:0] addr,
                                input logic known, input t_lookup known_res);
        int      gap;
        t_lookup exp_res;
        gap = 0;
        while (gap < 64 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            release_access_bus();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_address  <= addr;
        offering = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        exp_res = predict_lookup(cmd, addr);
        if (known)
            exp_res = known_res;
        pending_results.push_back(exp_res);
        n_accesses++;
        n_hits       += exp_res.hit;
        n_writebacks += exp_res.writeback;
    endtask

    // Random accesses: mostly a few hot sets and a small tag pool so that
    // hits, pLRU evictions and dirty writebacks are frequent; a few fully
    // random addresses keep every address bit moving.
    task automatic send_random_batch(input int count);
        logic [31:0] addr;
        logic [4:0]  set_idx;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                addr = $urandom();
            end else begin
                set_idx = (pick < 70) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
                addr    = {tag_pool[$urandom_range(0, TAG_POOL-1)], set_idx,
                           5'($urandom_range(0, 31))};
            end
            offer_access($urandom_range(0, 1) ? fwpct_pkg::CMD_WRITE : fwpct_pkg::CMD_READ,
                         addr, 1'b0, '0);
        end
    endtask

    // Hold the sender until every logged result has come back
    task automatic drain_results();
        release_access_bus();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: random stalls per cycle, plus a long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Compare each result beat, field by field, with the oldest expectation
    always @(posedge i_clk) begin
        t_lookup exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: hit %0b way %0d wb %0b",
                         $time, o_hit, o_way, o_writeback);
                mismatches++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_hit !== exp_res.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, exp_res.hit, o_hit);
                    mismatches++;
                end
                if (o_way !== exp_res.way) begin
                    $display("%0t: way expected %0d actual %0d", $time, exp_res.way, o_way);
                    mismatches++;
                end
                if (o_writeback !== exp_res.writeback) begin
                    $display("%0t: writeback expected %0b actual %0b", $time,
                             exp_res.writeback, o_writeback);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < 4; w++) begin
                tag_shadow[s][w]   = '0;
                valid_shadow[s][w] = 1'b0;
                dirty_shadow[s][w] = 1'b0;
            end
            plru_shadow[s] = '0;
        end
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int t = 2; t < TAG_POOL; t++)
            tag_pool[t] = TAG_W'($urandom());

        // Hold reset, then release it; the block then clears itself before the
        // first beat is taken, which the handshake absorbs
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase 0: no idling on either side
        for (int i = 0; i < N_DIR; i++)
            offer_access(DIRECTED[i].cmd, DIRECTED[i].addr, DIRECTED[i].known,
                         DIRECTED[i].res);
        send_random_batch(255);

        // Back-pressure: the sink holds off while beats keep coming, so the
        // result register fills and the input stalls
        rx_hold = 300;
        send_random_batch(20);
        drain_results();

        // Phase 1: sender idle most cycles
        tx_idle_pct = 87;
        send_random_batch(255);
        drain_results();

        // Phase 2: receiver stalling most cycles
        tx_idle_pct  = 0;
        rx_stall_pct = 87;
        send_random_batch(255);
        drain_results();

        // Phase 3: both sides idle now and then
        tx_idle_pct  = 31;
        rx_stall_pct = 31;
        send_random_batch(255);
        drain_results();

        // Let any stray result show up before closing
        repeat (20) @(posedge i_clk);

        $display("Ran %0d accesses (%0d from the table) over four idling phases",
                 n_accesses, N_DIR);
        $display("with %0d hits, %0d misses, %0d writebacks, %0d results checked",
                 n_hits, n_accesses - n_hits, n_writebacks, n_results);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
